// File: src/mcss_pkg.sv
// Package for the motor command safety supervisor: transaction payload types,
// winch and action codes, register indexes and register reset values.
// No dependencies.
`default_nettype none

package mcss_pkg;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_MS  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_LIMIT = 1'd1;

   localparam logic [31:0] TIMEOUT_MS_RESET  = 32'd500;
   localparam logic [14:0] DRIVE_LIMIT_RESET = 15'd400;

   localparam logic [1:0] WINCH_NONE = 2'd0;
   localparam logic [1:0] WINCH_UP   = 2'd1;
   localparam logic [1:0] WINCH_DOWN = 2'd2;
   localparam logic [1:0] WINCH_BAD  = 2'd3;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_ABORT = 2'd1;
   localparam logic [1:0] ACT_RAISE = 2'd2;
   localparam logic [1:0] ACT_LOWER = 2'd3;

   typedef struct packed {
      logic [31:0]        now_ms;
      logic               packet_valid;
      logic signed [15:0] drive_request;
      logic [1:0]         winch_request;
      logic               stop_request;
      logic [31:0]        sequence_in;
      logic               home_pressed;
      logic               winch_busy;
      logic               drive_fault;
   } req_type;

   typedef struct packed {
      logic signed [15:0] applied_drive;
      logic [1:0]         winch_action;
      logic [1:0]         active_winch;
      logic               link_timed_out;
      logic               stop_active;
      logic [31:0]        last_sequence;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/mcss_req_if.sv
// Request channel interface: valid/ready handshake with one control pass.
// Depends on mcss_pkg.
`default_nettype none

interface mcss_req_if;
   logic             valid;
   logic             ready;
   mcss_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/mcss_rsp_if.sv
// Response channel interface: valid/ready handshake with one supervisor result.
// Depends on mcss_pkg.
`default_nettype none

interface mcss_rsp_if;
   logic             valid;
   logic             ready;
   mcss_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/motor_command_safety_supervisor.sv
// Motor command safety supervisor top level: request register, supervisor
// logic and response register. Depends on mcss_pkg, mcss_req_if, mcss_rsp_if.
//
//   channel | direction | handshake          | payload
//   req_ch  | in        | valid/ready        | mcss_pkg::req_type
//   rsp_ch  | out       | valid/ready        | mcss_pkg::rsp_type
//   csr_*   | in        | write enable only  | index, 32-bit data
//
// One transaction per cycle unless the response stalls; a transaction passes
// the request register and then the response register. Supervisor state updates
// when a transaction moves from the request register to the response register.
// A stalled response holds both registers; reset clears the valids and state.
`default_nettype none

module motor_command_safety_supervisor (
   input  wire logic                               clock,
   input  wire logic                               reset,
   mcss_req_if.sink                                req_ch,
   mcss_rsp_if.source                              rsp_ch,
   input  wire logic                               csr_write_enable,
   input  wire logic [mcss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mcss_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic [31:0]        timeout_ms_ff;
   logic [14:0]        drive_limit_ff;

   logic               s1_valid_ff;
   mcss_pkg::req_type  s1_data_ff;
   logic               rsp_valid_ff;
   mcss_pkg::rsp_type  rsp_data_ff;

   logic signed [15:0] held_drive_ff, held_drive_in;
   logic [1:0]         held_winch_ff, held_winch_in;
   logic [31:0]        held_sequence_ff, held_sequence_in;
   logic               stop_latched_ff, stop_latched_in;
   logic               ever_received_ff, ever_received_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic [1:0]         current_winch_ff, current_winch_in;
   logic               safety_done_ff, safety_done_in;

   logic               advance;
   logic [31:0]        elapsed;
   logic               timed_out;
   logic               safe_stop;
   logic [1:0]         action;
   logic signed [16:0] drive_src;
   logic signed [16:0] limit_pos;
   logic signed [16:0] drive_clamped;
   logic signed [15:0] drive_out;
   mcss_pkg::rsp_type  rsp_in;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ms_ff  <= mcss_pkg::TIMEOUT_MS_RESET;
         drive_limit_ff <= mcss_pkg::DRIVE_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mcss_pkg::CSR_TIMEOUT_MS:  timeout_ms_ff  <= csr_write_data;
            mcss_pkg::CSR_DRIVE_LIMIT: drive_limit_ff <= csr_write_data[14:0];
            default: ;
         endcase
      end
   end

   // latch packet fields
   always_comb begin
      if (s1_data_ff.packet_valid) begin
         held_drive_in    = s1_data_ff.drive_request;
         held_winch_in    = (s1_data_ff.winch_request == mcss_pkg::WINCH_BAD) ?
                            mcss_pkg::WINCH_NONE : s1_data_ff.winch_request;
         held_sequence_in = s1_data_ff.sequence_in;
         stop_latched_in  = s1_data_ff.stop_request;
         last_time_in     = s1_data_ff.now_ms;
      end else begin
         held_drive_in    = held_drive_ff;
         held_winch_in    = held_winch_ff;
         held_sequence_in = held_sequence_ff;
         stop_latched_in  = stop_latched_ff;
         last_time_in     = last_time_ff;
      end
      ever_received_in = ever_received_ff || s1_data_ff.packet_valid;
   end

   assign elapsed   = s1_data_ff.now_ms - last_time_in;
   assign timed_out = !ever_received_in || (elapsed > timeout_ms_ff);
   assign safe_stop = stop_latched_in || timed_out;

   // winch arbitration
   always_comb begin
      action           = mcss_pkg::ACT_NONE;
      current_winch_in = current_winch_ff;
      safety_done_in   = safety_done_ff;
      if (safe_stop) begin
         if (!safety_done_ff) begin
            action = (current_winch_ff != mcss_pkg::WINCH_NONE || s1_data_ff.winch_busy) ?
                     mcss_pkg::ACT_ABORT : mcss_pkg::ACT_NONE;
            current_winch_in = mcss_pkg::WINCH_NONE;
            safety_done_in   = 1'b1;
         end
      end else begin
         safety_done_in = 1'b0;
         priority if (held_winch_in == mcss_pkg::WINCH_NONE ||
                      (held_winch_in == mcss_pkg::WINCH_UP && s1_data_ff.home_pressed)) begin
            action = (current_winch_ff != mcss_pkg::WINCH_NONE || s1_data_ff.winch_busy) ?
                     mcss_pkg::ACT_ABORT : mcss_pkg::ACT_NONE;
            current_winch_in = mcss_pkg::WINCH_NONE;
         end else if (current_winch_ff != held_winch_in) begin
            priority if (current_winch_ff != mcss_pkg::WINCH_NONE || s1_data_ff.winch_busy) begin
               action           = mcss_pkg::ACT_ABORT;
               current_winch_in = mcss_pkg::WINCH_NONE;
            end else if (held_winch_in == mcss_pkg::WINCH_UP) begin
               action           = mcss_pkg::ACT_RAISE;
               current_winch_in = mcss_pkg::WINCH_UP;
            end else begin
               action           = mcss_pkg::ACT_LOWER;
               current_winch_in = mcss_pkg::WINCH_DOWN;
            end
         end else begin
            action = mcss_pkg::ACT_NONE;
         end
      end
   end

   // clamp drive
   always_comb begin
      drive_src = (held_winch_in != mcss_pkg::WINCH_NONE) ? 17'sd0 :
                  17'(held_drive_in);
      limit_pos = $signed({2'b00, drive_limit_ff});
      priority if (drive_src > limit_pos) begin
         drive_clamped = limit_pos;
      end else if (drive_src < -limit_pos) begin
         drive_clamped = -limit_pos;
      end else begin
         drive_clamped = drive_src;
      end
      if (safe_stop || s1_data_ff.drive_fault) begin
         drive_out = 16'sd0;
      end else begin
         drive_out = drive_clamped[15:0];
      end
   end

   always_comb begin
      rsp_in.applied_drive  = drive_out;
      rsp_in.winch_action   = action;
      rsp_in.active_winch   = current_winch_in;
      rsp_in.link_timed_out = timed_out;
      rsp_in.stop_active    = stop_latched_in;
      rsp_in.last_sequence  = held_sequence_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         held_drive_ff    <= 16'sd0;
         held_winch_ff    <= mcss_pkg::WINCH_NONE;
         held_sequence_ff <= 32'd0;
         stop_latched_ff  <= 1'b0;
         ever_received_ff <= 1'b0;
         last_time_ff     <= 32'd0;
         current_winch_ff <= mcss_pkg::WINCH_NONE;
         safety_done_ff   <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff     <= 1'b1;
            held_drive_ff    <= held_drive_in;
            held_winch_ff    <= held_winch_in;
            held_sequence_ff <= held_sequence_in;
            stop_latched_ff  <= stop_latched_in;
            ever_received_ff <= ever_received_in;
            last_time_ff     <= last_time_in;
            current_winch_ff <= current_winch_in;
            safety_done_ff   <= safety_done_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_data_ff <= req_ch.data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
